// ===== hdl/bbig_pkg.sv =====
`timescale 1ns / 1ps
// Package for the broadcast batch index generator.
// Holds widths, register indexes, payload types and controller/datapath structs.
package bbig_pkg;

  localparam int IDX_W          = 30;  // width of every linear batch index
  localparam int CFG_W          = 11;  // width of a size register
  localparam int REG_DIMS       = 3;   // batch dimensions backed by registers
  localparam int CFG_IDX_W      = 3;   // register index width
  localparam int BATCH_DIMS_DEF = 3;
  localparam int SIZE_BITS_DEF  = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_SIZE_D0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_SIZE_D0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS  = 3'd6;

  typedef struct packed {
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] a_batch_index;
    logic [IDX_W-1:0] b_batch_index;
    logic [IDX_W-1:0] out_batch_index;
    logic             final_batch;
    logic             size_mismatch;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // input transfer: apply restart, clear accumulators
    logic calc;   // run one Horner step
    logic load;   // load output register, advance the odometer
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic calc_last;  // current Horner step is the last one
  } dp_status_t;

endpackage

// ===== hdl/bbig_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interface used for the input and result channels.
// Payload type is a parameter; the block uses types from bbig_pkg.
interface bbig_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/broadcast_batch_index_generator.sv =====
`timescale 1ns / 1ps
// Broadcast batch index generator: top level joining controller and datapath.
// Depends on bbig_pkg, bbig_stream_if, bbig_ctrl and bbig_dp.
//
// Usage:
//   Write the six batch size registers (A sizes, then B sizes) through the
//   cfg_* port while the block is idle. Each input transfer carries a restart
//   bit: 1 emits batch zero, 0 emits the next batch of the odometer. Each input
//   yields exactly one result with the A, B and output linear batch indices,
//   a final-batch flag (the odometer wraps to zero after it) and a flag for
//   incompatible sizes.
// Timing:
//   The Horner unit takes one batch dimension per cycle. An item is taken in
//   the input transfer, then gets one Horner step per dimension, and is then
//   loaded into the output register, which drives the result on the output.
// Reset:
//   Size registers return to 1, odometer and linear counter to zero, and both
//   channels go empty.
// Stall:
//   A result waits in the output register; the next item is still taken and
//   computed, and then holds until the output register frees up.
module broadcast_batch_index_generator #(
  parameter int BATCH_DIMS = bbig_pkg::BATCH_DIMS_DEF,
  parameter int SIZE_BITS  = bbig_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbig_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbig_pkg::CFG_W-1:0]     cfg_data_i,
  bbig_stream_if.sink                    in_i,
  bbig_stream_if.source                  out_o
);
  import bbig_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  out_item_t  result;
  in_item_t   in_item;

  assign in_item = in_i.payload;

  // Sequence accept, Horner steps and result load
  bbig_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold sizes and odometer, evaluate the indices
  bbig_dp #(
    .BATCH_DIMS (BATCH_DIMS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .restart_i  (in_item.restart),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result)
  );

  assign out_o.payload = result;

endmodule

// ===== hdl/bbig_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the broadcast batch index generator.
// Depends on bbig_pkg; drives datapath commands and the result valid.
module bbig_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  bbig_pkg::dp_status_t   status_i,
  output bbig_pkg::ctrl_cmd_t    cmd_o
);
  import bbig_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.start = accept;
  assign cmd_o.calc  = (state_q == ST_CALC);
  assign cmd_o.load  = (state_q == ST_DONE) && out_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (status_i.calc_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = accept ? ST_CALC : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/bbig_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the broadcast batch index generator: size registers, odometer,
// Horner accumulators and result register. Depends on bbig_pkg.
module bbig_dp #(
  parameter int BATCH_DIMS = bbig_pkg::BATCH_DIMS_DEF,
  parameter int SIZE_BITS  = bbig_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbig_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbig_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           restart_i,
  input  bbig_pkg::ctrl_cmd_t            cmd_i,
  output bbig_pkg::dp_status_t           status_o,
  output bbig_pkg::out_item_t            result_o
);
  import bbig_pkg::*;

  localparam int SW     = SIZE_BITS + 1;
  localparam int STEP_W = (BATCH_DIMS > 1) ? $clog2(BATCH_DIMS) : 1;
  localparam int PW     = IDX_W + SW;

  logic [CFG_W-1:0]     a_size_q [REG_DIMS];
  logic [CFG_W-1:0]     b_size_q [REG_DIMS];
  logic [SIZE_BITS-1:0] cnt_q    [BATCH_DIMS];
  logic [SIZE_BITS-1:0] cnt_d    [BATCH_DIMS];
  logic [SIZE_BITS-1:0] cnt_adv  [BATCH_DIMS];
  logic [IDX_W-1:0]     lin_q, lin_d;
  logic [IDX_W-1:0]     acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic [STEP_W-1:0]    step_q, step_d;
  out_item_t            result_q;

  logic [SW-1:0]         a_eff   [BATCH_DIMS];
  logic [SW-1:0]         b_eff   [BATCH_DIMS];
  logic [SW-1:0]         out_eff [BATCH_DIMS];
  logic [BATCH_DIMS-1:0] at_end;
  logic [BATCH_DIMS-1:0] dim_mismatch;
  logic                  last;

  logic [SIZE_BITS-1:0] digit;
  logic [SW-1:0]        sa, sb;
  logic [PW-1:0]        prod_a, prod_b;

  // Zero counts as one; clamp to the largest size the digits can count.
  function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] raw);
    logic [31:0] s;
    s = 32'(raw);
    if (s == 32'd0) begin
      s = 32'd1;
    end
    if (s > (32'd1 << SIZE_BITS)) begin
      s = 32'd1 << SIZE_BITS;
    end
    return s[SW-1:0];
  endfunction

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_DIMS; i++) begin
        a_size_q[i] <= CFG_W'(1);
        b_size_q[i] <= CFG_W'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_B_SIZE_D0) begin
        a_size_q[2'(cfg_idx_i - CFG_A_SIZE_D0)] <= cfg_data_i;
      end else if (cfg_idx_i < CFG_NUM_REGS) begin
        b_size_q[2'(cfg_idx_i - CFG_B_SIZE_D0)] <= cfg_data_i;
      end
    end
  end

  // Per-dimension sizes and flags
  for (genvar d = 0; d < BATCH_DIMS; d++) begin : g_dim
    if (d < REG_DIMS) begin : g_reg
      assign a_eff[d] = eff_size(a_size_q[d]);
      assign b_eff[d] = eff_size(b_size_q[d]);
    end else begin : g_one
      assign a_eff[d] = SW'(1);
      assign b_eff[d] = SW'(1);
    end
    assign out_eff[d]      = (a_eff[d] > b_eff[d]) ? a_eff[d] : b_eff[d];
    assign at_end[d]       = {1'b0, cnt_q[d]} >= (out_eff[d] - SW'(1));
    assign dim_mismatch[d] = (a_eff[d] != SW'(1)) && (b_eff[d] != SW'(1)) &&
                             (a_eff[d] != b_eff[d]);
  end

  assign last = &at_end;

  // Odometer advance, first dimension fastest
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = 0; d < BATCH_DIMS; d++) begin
      cnt_adv[d] = cnt_q[d];
      if (carry) begin
        if (at_end[d]) begin
          cnt_adv[d] = '0;
        end else begin
          cnt_adv[d] = cnt_q[d] + SIZE_BITS'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < BATCH_DIMS; d++) begin
      cnt_d[d] = cnt_q[d];
      if (cmd_i.start && restart_i) begin
        cnt_d[d] = '0;
      end else if (cmd_i.load) begin
        cnt_d[d] = cnt_adv[d];
      end
    end
    lin_d = lin_q;
    if (cmd_i.start && restart_i) begin
      lin_d = '0;
    end else if (cmd_i.load) begin
      lin_d = last ? '0 : lin_q + IDX_W'(1);
    end
  end

  // One Horner step per cycle, last dimension first
  assign digit  = cnt_q[step_q];
  assign sa     = a_eff[step_q];
  assign sb     = b_eff[step_q];
  assign prod_a = PW'(acc_a_q) * PW'(sa);
  assign prod_b = PW'(acc_b_q) * PW'(sb);

  always_comb begin
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    step_d  = step_q;
    if (cmd_i.start) begin
      acc_a_d = '0;
      acc_b_d = '0;
      step_d  = STEP_W'(BATCH_DIMS - 1);
    end else if (cmd_i.calc) begin
      if (sa > SW'(1)) begin
        acc_a_d = prod_a[IDX_W-1:0] + IDX_W'(digit);
      end
      if (sb > SW'(1)) begin
        acc_b_d = prod_b[IDX_W-1:0] + IDX_W'(digit);
      end
      if (step_q != '0) begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  assign status_o.calc_last = (step_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < BATCH_DIMS; d++) begin
        cnt_q[d] <= '0;
      end
      lin_q  <= '0;
      step_q <= '0;
    end else begin
      for (int d = 0; d < BATCH_DIMS; d++) begin
        cnt_q[d] <= cnt_d[d];
      end
      lin_q  <= lin_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
    if (cmd_i.load) begin
      result_q.a_batch_index   <= acc_a_q;
      result_q.b_batch_index   <= acc_b_q;
      result_q.out_batch_index <= lin_q;
      result_q.final_batch     <= last;
      result_q.size_mismatch   <= |dim_mismatch;
    end
  end

  assign result_o = result_q;

endmodule

// ===== hdl/bbig_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the broadcast batch index generator, with its bind.
// Depends on bbig_pkg for the result type.
module bbig_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bbig_pkg::out_item_t out_payload_i
);
  import bbig_pkg::*;

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result changed while stalled");

  // The block is busy computing right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken during computation");

  // A final batch at output index zero is the only batch of the walk, so every
  // size is one and both operand indices are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_payload_i.final_batch &&
    out_payload_i.out_batch_index == '0
    |-> out_payload_i.a_batch_index == '0 && out_payload_i.b_batch_index == '0)
    else $error("single-batch result with nonzero operand index");

endmodule

bind broadcast_batch_index_generator bbig_checker u_bbig_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
